### hw/rtl/pcenc_pkg.sv
// ----------------------------------------------------------------------------
// pcenc_pkg
// Shared constants, types and the in-word butterfly network of the polar
// encoder.
// ----------------------------------------------------------------------------
package pcenc_pkg;

	localparam int WORD_BITS   = 32;
	localparam int WORD_LOG    = 5;
	localparam int SIZE_W      = 4;
	localparam int MAX_LOG_DEF = 10;

	// Word read for output is in flight
	typedef struct packed {
		logic valid;
		logic last;
	} emit_t;

	// Polar stages that stay inside one word (sub-blocks of 2..32 bits), then
	// zero the bits at and above N for short blocks.
	function automatic logic [WORD_BITS-1:0] xform_word(
		input logic [WORD_BITS-1:0] w,
		input logic [SIZE_W-1:0]    slog
	);
		logic [WORD_BITS-1:0] r;
		logic [WORD_BITS-1:0] one;
		r   = w;
		one = WORD_BITS'(1);
		for (int s = 0; s < WORD_LOG; s++) begin
			if (SIZE_W'(s) < slog) begin
				for (int i = 0; i < WORD_BITS; i++) begin
					if (!i[s]) begin
						r[i] = r[i] ^ r[i + (1 << s)];
					end
				end
			end
		end
		if (slog < SIZE_W'(WORD_LOG)) begin
			r = r & ((one << (one << slog)) - one);
		end
		return r;
	endfunction

endpackage

### hw/rtl/pcenc_ram.sv
// ----------------------------------------------------------------------------
// pcenc_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module pcenc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

### hw/rtl/pcenc_out.sv
// ----------------------------------------------------------------------------
// pcenc_out
// Output stage: finishes the in-word polar stages and registers the result.
// ----------------------------------------------------------------------------
module pcenc_out (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  pcenc_pkg::emit_t                     emit,
	input  logic [pcenc_pkg::SIZE_W-1:0]         slog,
	input  logic [pcenc_pkg::WORD_BITS-1:0]      rdata,
	output logic                                 code_valid,
	output logic [pcenc_pkg::WORD_BITS-1:0]      code_word,
	output logic                                 last_word
);

	logic                               valid_q;
	logic                               last_q;
	logic [pcenc_pkg::WORD_BITS-1:0]    word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= emit.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid) begin
			word_q <= pcenc_pkg::xform_word(rdata, slog);
			last_q <= emit.last;
		end
	end

	assign code_valid = valid_q;
	assign code_word  = word_q;
	assign last_word  = last_q;

endmodule

### hw/rtl/polar_code_encoder.sv
// ----------------------------------------------------------------------------
// polar_code_encoder
// Natural-order polar transform over a block of N = 2^size_log bits.
// ----------------------------------------------------------------------------
// Words are loaded one per cycle while busy is low; a load that does not
// finish a block leaves busy low. After the final word of a block, busy rises
// and one shared XOR unit on a dual-read RAM runs the stages that span words:
// for n = size_log > 5 that is (n-5) passes of N/64 word updates, each pass
// followed by a drain state, then N/32 reads out, one word a cycle, through
// the registered RAM read and the output register. Blocks of 32 bits or less
// go straight to the readout. Each code word shows on code_word for one cycle
// with code_valid; the receiver cannot stall, and the next load may start in
// the cycle of the last word. A word counter sets the block boundary; size_log
// writes are accepted at any time and are meant for idle periods.
// ----------------------------------------------------------------------------
module polar_code_encoder #(
	parameter int MAX_LOG = pcenc_pkg::MAX_LOG_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [pcenc_pkg::WORD_BITS-1:0]   data_word,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pcenc_pkg::SIZE_W-1:0]      size_log,
	output logic                              code_valid,
	output logic [pcenc_pkg::WORD_BITS-1:0]   code_word,
	output logic                              last_word
);

	localparam int MAX_WORDS = (1 << MAX_LOG) / pcenc_pkg::WORD_BITS;
	localparam int AW        = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int DEPTH     = 1 << AW;
	localparam int CW        = $clog2(MAX_WORDS + 1);
	localparam int SW        = pcenc_pkg::SIZE_W;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_XOR   = 5'b00010,
		ST_DRAIN = 5'b00100,
		ST_EMIT  = 5'b01000,
		ST_FLUSH = 5'b10000
	} state_t;

	state_t              state_q;
	logic [SW-1:0]       size_log_q;
	logic [CW-1:0]       words_loaded_q;
	logic [SW-1:0]       nw_log_q;
	logic [SW-1:0]       slog_q;
	logic [SW-1:0]       st_q;
	logic [AW-1:0]       k_q;
	logic [AW-1:0]       w_q;
	logic                wr_s1;
	logic [AW-1:0]       wa_s1;
	pcenc_pkg::emit_t    emit_s1;

	logic                accept;
	logic                room;
	logic [SW-1:0]       nw_log;
	logic [CW-1:0]       count_nxt;
	logic                complete;
	logic [AW-1:0]       nwm1;
	logic [AW-1:0]       ops_m1;
	logic [AW-1:0]       half;
	logic [AW-1:0]       lo_mask;
	logic [AW-1:0]       addr_a;
	logic [AW-1:0]       addr_b;
	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [pcenc_pkg::WORD_BITS-1:0] ram_wdata;
	logic [AW-1:0]       ram_raddr_a;
	logic [pcenc_pkg::WORD_BITS-1:0] rd_a;
	logic [pcenc_pkg::WORD_BITS-1:0] rd_b;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign room      = (words_loaded_q < CW'(MAX_WORDS));

	always_comb begin
		nw_log    = (size_log_q > SW'(pcenc_pkg::WORD_LOG)) ?
		            size_log_q - SW'(pcenc_pkg::WORD_LOG) : '0;
		count_nxt = words_loaded_q + CW'(room);
		complete  = (count_nxt >= (CW'(1) << nw_log));
		nwm1      = AW'((CW'(1) << nw_log_q) - CW'(1));
		ops_m1    = nwm1 >> 1;
		// butterfly pair: insert a zero at bit st into the op index
		half      = AW'(1) << st_q;
		lo_mask   = half - AW'(1);
		addr_a    = ((k_q & ~lo_mask) << 1) | (k_q & lo_mask);
		addr_b    = addr_a | half;
	end

	// one writer at a time: loads only in idle, XOR write-back only while busy
	always_comb begin
		ram_we      = wr_s1 || (accept && room);
		ram_waddr   = wr_s1 ? wa_s1 : words_loaded_q[AW-1:0];
		ram_wdata   = wr_s1 ? (rd_a ^ rd_b) : data_word;
		ram_raddr_a = (state_q == ST_EMIT) ? w_q : addr_a;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_log_q <= SW'(MAX_LOG);
		end else if (cfg_valid && cfg_ready) begin
			size_log_q <= (size_log > SW'(MAX_LOG)) ? SW'(MAX_LOG) : size_log;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			words_loaded_q <= '0;
			nw_log_q       <= '0;
			slog_q         <= '0;
			st_q           <= '0;
			k_q            <= '0;
			w_q            <= '0;
			wr_s1          <= 1'b0;
			wa_s1          <= '0;
			emit_s1        <= '0;
		end else begin
			wr_s1         <= 1'b0;
			emit_s1.valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (complete) begin
							words_loaded_q <= '0;
							nw_log_q       <= nw_log;
							slog_q         <= size_log_q;
							st_q           <= '0;
							k_q            <= '0;
							w_q            <= '0;
							state_q        <= (nw_log == '0) ? ST_EMIT : ST_XOR;
						end else begin
							words_loaded_q <= count_nxt;
						end
					end
				end
				ST_XOR: begin
					wr_s1 <= 1'b1;
					wa_s1 <= addr_a;
					if (k_q == ops_m1) begin
						k_q     <= '0;
						state_q <= ST_DRAIN;
					end else begin
						k_q <= k_q + AW'(1);
					end
				end
				ST_DRAIN: begin
					// last write of the pass lands here, before the next pass reads
					if (st_q == nw_log_q - SW'(1)) begin
						state_q <= ST_EMIT;
					end else begin
						st_q    <= st_q + SW'(1);
						state_q <= ST_XOR;
					end
				end
				ST_EMIT: begin
					emit_s1.valid <= 1'b1;
					emit_s1.last  <= (w_q == nwm1);
					if (w_q == nwm1) begin
						state_q <= ST_FLUSH;
					end else begin
						w_q <= w_q + AW'(1);
					end
				end
				ST_FLUSH: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	pcenc_ram #(
		.WIDTH (pcenc_pkg::WORD_BITS),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (ram_raddr_a),
		.raddr_b (addr_b),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	pcenc_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.emit       (emit_s1),
		.slog       (slog_q),
		.rdata      (rd_a),
		.code_valid (code_valid),
		.code_word  (code_word),
		.last_word  (last_word)
	);

endmodule

### hw/rtl/pcenc_chk.sv
// ----------------------------------------------------------------------------
// pcenc_chk
// Port-level checks of the polar encoder, bound to the top level.
// ----------------------------------------------------------------------------
module pcenc_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic                              cfg_valid,
	input logic                              cfg_ready,
	input logic                              code_valid,
	input logic                              last_word
);

	// a freshly loaded word never shows up as output in the next cycle
	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !code_valid)
		else $error("code word one cycle after a load");

	// words of one block come out back to back
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(code_valid && !last_word) |=> code_valid)
		else $error("gap inside a code block");

	a_busy_mid: assert property (@(posedge clk) disable iff (!arst_n)
		(code_valid && !last_word) |-> busy)
		else $error("idle while a block is still going out");

	a_idle_last: assert property (@(posedge clk) disable iff (!arst_n)
		(code_valid && last_word) |-> !busy)
		else $error("still busy on the last word");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("size write not taken");

endmodule

bind polar_code_encoder pcenc_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.cfg_valid  (cfg_valid),
	.cfg_ready  (cfg_ready),
	.code_valid (code_valid),
	.last_word  (last_word)
);

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for polar_code_encoder: loads blocks of input words over
// the start/busy port at several code sizes (the extremes, oversized writes and
// a size change inside a block among them), encodes each finished block in the
// bench, and checks every strobed code word and its last flag in order.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int MAX_LOG     = pcenc_pkg::MAX_LOG_DEF;
	localparam int WB          = pcenc_pkg::WORD_BITS;
	localparam int MAX_BITS    = 1 << MAX_LOG;
	localparam int MAX_WORDS   = (MAX_BITS + WB - 1) / WB;
	localparam int ITEM_TARGET = 310;
	localparam int STALL_LIMIT = 2000;
	localparam int IDLE_MARGIN = 8;

	typedef struct packed {
		logic [WB-1:0] word;
		logic          last;
	} code_exp_t;

	logic                          clk        = 1'b0;
	logic                          arst_n     = 1'b0;
	logic                          start      = 1'b0;
	logic                          busy;
	logic [WB-1:0]                 data_word  = '0;
	logic                          cfg_valid  = 1'b0;
	logic                          cfg_ready;
	logic [pcenc_pkg::SIZE_W-1:0]  size_log   = '0;
	logic                          code_valid;
	logic [WB-1:0]                 code_word;
	logic                          last_word;

	// input words waiting for the driver, expected code words in order
	logic [WB-1:0] load_q[$];
	code_exp_t     codeword_q[$];

	// bench copy of the encoder state
	logic [WB-1:0] blk_words [MAX_WORDS];
	int unsigned   blk_fill = 0;
	int unsigned   cur_log  = MAX_LOG;

	int unsigned   load_gap    = 0;
	bit            no_gap_run  = 1'b0;
	int unsigned   stall_cycles = 0;
	int unsigned   mismatch_count = 0;
	code_exp_t     mon_exp;

	polar_code_encoder DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.data_word  (data_word),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.size_log   (size_log),
		.code_valid (code_valid),
		.code_word  (code_word),
		.last_word  (last_word)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int unsigned clamp_log(input logic [pcenc_pkg::SIZE_W-1:0] l);
		return (l > MAX_LOG) ? MAX_LOG : l;
	endfunction

	function automatic int unsigned words_for(input int unsigned lg);
		return ((1 << lg) + WB - 1) / WB;
	endfunction

	// Store one accepted word; on a finished block run the Kronecker transform
	// over the first N bits and queue the resulting code words.
	function automatic void polar_absorb(input logic [WB-1:0] w);
		logic [MAX_BITS-1:0] u;
		int unsigned nbits;
		int unsigned nwords;
		if (blk_fill < MAX_WORDS) begin
			blk_words[blk_fill] = w;
			blk_fill++;
		end
		nbits  = 1 << cur_log;
		nwords = words_for(cur_log);
		if (blk_fill < nwords)
			return;
		u = '0;
		for (int i = 0; i < nbits; i++)
			u[i] = blk_words[i / WB][i % WB];
		for (int sz = 2; sz <= nbits; sz <<= 1)
			for (int b = 0; b < nbits; b += sz)
				for (int k = 0; k < sz / 2; k++)
					u[b + k] = u[b + k] ^ u[b + k + sz / 2];
		for (int w2 = 0; w2 < nwords; w2++)
			codeword_q.push_back('{word: u[w2 * WB +: WB], last: (w2 + 1 == nwords)});
		blk_fill = 0;
	endfunction

	function automatic logic [WB-1:0] rand_data();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return WB'(1) << $urandom_range(0, WB - 1);
			default: return $urandom;
		endcase
	endfunction

	// driver: one word per start/busy handshake, random gap drawn per word
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start     <= 1'b0;
			data_word <= '0;
		end else begin
			if (start && !busy)
				polar_absorb(data_word);
			if (!start || !busy) begin
				if (load_gap != 0) begin
					load_gap--;
					start <= 1'b0;
				end else if (load_q.size() != 0) begin
					start     <= 1'b1;
					data_word <= load_q.pop_front();
					if ($urandom_range(0, 15) == 0)
						no_gap_run = !no_gap_run;
					load_gap = no_gap_run ? 0 : $urandom_range(0, 10);
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: every strobed word is checked against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && code_valid) begin
			if (codeword_q.size() == 0) begin
				mismatch_count++;
				$display("%0t unexpected code word: expected none, actual %h last %b",
					$time, code_word, last_word);
			end else begin
				mon_exp = codeword_q.pop_front();
				if (code_word !== mon_exp.word) begin
					mismatch_count++;
					$display("%0t code_word mismatch: expected %h, actual %h",
						$time, mon_exp.word, code_word);
				end
				if (last_word !== mon_exp.last) begin
					mismatch_count++;
					$display("%0t last_word mismatch: expected %b, actual %b",
						$time, mon_exp.last, last_word);
				end
			end
		end
	end

	// watchdog on cycles with no handshake of any kind
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || code_valid || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic set_size(input logic [pcenc_pkg::SIZE_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		size_log  <= v;
		do @(posedge clk); while (!cfg_ready);
		cur_log   = clamp_log(v);
		cfg_valid <= 1'b0;
	endtask

	// all words sent, all code words seen, then an idle margin;
	// checked mid-cycle so the driver's edge updates have settled
	task automatic wait_idle();
		do @(negedge clk);
		while (load_q.size() != 0 || start || busy || codeword_q.size() != 0);
		repeat (IDLE_MARGIN) @(posedge clk);
	endtask

	initial begin
		int unsigned items_sent;
		int unsigned nwords;
		int unsigned nblk;
		int unsigned phase;
		logic [pcenc_pkg::SIZE_W-1:0] sel;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// N = 1: only bit 0 passes
		set_size(4'd0);
		load_q.push_back('1);
		load_q.push_back(32'h0000_0001);
		load_q.push_back(32'hFFFF_FFFE);
		wait_idle();
		// one full word
		set_size(4'd5);
		load_q.push_back('1);
		load_q.push_back(32'h8000_0000);
		load_q.push_back(32'h0000_0001);
		load_q.push_back('0);
		wait_idle();
		// short block, upper input bits ignored
		set_size(4'd3);
		load_q.push_back('1);
		load_q.push_back(32'hAAAA_AAAA);
		wait_idle();
		// first stage that spans words
		set_size(4'd6);
		load_q.push_back('1);
		load_q.push_back(32'h8000_0000);
		wait_idle();
		// size drops below the words already held: next word closes the block
		set_size(4'd7);
		load_q.push_back(32'h1234_5678);
		load_q.push_back(32'h9ABC_DEF0);
		load_q.push_back('1);
		wait_idle();
		set_size(4'd6);
		load_q.push_back(32'h0F0F_0F0F);
		wait_idle();

		items_sent = 0;
		phase      = 0;
		while (items_sent < ITEM_TARGET) begin
			case (phase)
				0: sel = 4'd15;
				1: sel = 4'd1;
				2: sel = 4'd10;
				default: sel = pcenc_pkg::SIZE_W'(($urandom_range(0, 7) == 0) ?
				                   $urandom_range(10, 15) : $urandom_range(0, 9));
			endcase
			set_size(sel);
			nwords = words_for(clamp_log(sel));
			nblk   = (nwords >= 16) ? 1 : $urandom_range(2, 24 / nwords + 1);
			for (int b = 0; b < nblk * nwords; b++)
				load_q.push_back(rand_data());
			items_sent += nblk * nwords;
			// sometimes leave a partial block across the next size write
			if (nwords > 1 && $urandom_range(0, 3) == 0) begin
				nblk = $urandom_range(1, nwords - 1);
				for (int b = 0; b < nblk; b++)
					load_q.push_back(rand_data());
				items_sent += nblk;
			end
			wait_idle();
			phase++;
		end

		wait_idle();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
